// File: rtl/pnod_pkg.sv
// Package: shared types, constants and functions of the palette quantizer.
`timescale 1ns / 1ps
package pnod_pkg;
   localparam int PALETTE_ENTRIES = 16;
   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam int DIST_W = 20;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_PASS    = 2'd0;
   localparam mode_type MODE_NEAREST = 2'd1;
   localparam mode_type MODE_DITHER  = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic CSR_MODE     = 1'b0;
   localparam logic CSR_STRENGTH = 1'b1;

   typedef struct packed {
      logic        command;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [1:0]  pos_x;
      logic [1:0]  pos_y;
      logic [3:0]  entry_index;
      logic [23:0] entry_color;
   } req_type;

   typedef struct packed {
      logic [3:0] palette_index;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      logic       index;
      logic [9:0] data;
   } csr_type;

   function automatic logic [23:0] default_color(input logic [3:0] i);
      case (i)
         4'd0:  default_color = 24'h000000;
         4'd1:  default_color = 24'h1D2B53;
         4'd2:  default_color = 24'h7E2553;
         4'd3:  default_color = 24'h008751;
         4'd4:  default_color = 24'hAB5236;
         4'd5:  default_color = 24'h5F574F;
         4'd6:  default_color = 24'hC2C3C7;
         4'd7:  default_color = 24'hFFF1E8;
         4'd8:  default_color = 24'hFF004D;
         4'd9:  default_color = 24'hFFA300;
         4'd10: default_color = 24'hFFEC27;
         4'd11: default_color = 24'h00E436;
         4'd12: default_color = 24'h29ADFF;
         4'd13: default_color = 24'h83769C;
         4'd14: default_color = 24'hFF77A8;
         default: default_color = 24'hFFCCAA;
      endcase
   endfunction

   function automatic logic [3:0] bayer(input logic [3:0] yx);
      case (yx)
         4'd0: bayer = 4'd0;   4'd1: bayer = 4'd8;   4'd2: bayer = 4'd2;
         4'd3: bayer = 4'd10;  4'd4: bayer = 4'd12;  4'd5: bayer = 4'd4;
         4'd6: bayer = 4'd14;  4'd7: bayer = 4'd6;   4'd8: bayer = 4'd3;
         4'd9: bayer = 4'd11;  4'd10: bayer = 4'd1;  4'd11: bayer = 4'd9;
         4'd12: bayer = 4'd15; 4'd13: bayer = 4'd7;  4'd14: bayer = 4'd13;
         default: bayer = 4'd5;
      endcase
   endfunction

   function automatic logic [7:0] widen(input logic [7:0] c);
      widen = {c[7:3], c[7:5]};
   endfunction

   function automatic logic [7:0] add_clamp(input logic [7:0] c, input logic signed [9:0] off);
      logic signed [10:0] v;
      v = $signed({3'b000, c}) + 11'(off);
      if (v < 0) add_clamp = 8'd0;
      else if (v > 11'sd255) add_clamp = 8'd255;
      else add_clamp = v[7:0];
   endfunction

   // Weighted distance 3*dr^2 + 4*dg^2 + 2*db^2; the largest value needs 20 bits.
   function automatic logic [DIST_W-1:0] color_dist(input logic [23:0] p,
                                                    input logic [23:0] c);
      logic [7:0] dr, dg, db;
      logic [15:0] sr, sg, sb;
      dr = p[23:16] > c[23:16] ? p[23:16] - c[23:16] : c[23:16] - p[23:16];
      dg = p[15:8] > c[15:8] ? p[15:8] - c[15:8] : c[15:8] - p[15:8];
      db = p[7:0] > c[7:0] ? p[7:0] - c[7:0] : c[7:0] - p[7:0];
      sr = dr * dr;
      sg = dg * dg;
      sb = db * db;
      color_dist = 20'(sr) * 20'd3 + {2'b00, sg, 2'b00} + {3'b000, sb, 1'b0};
   endfunction
endpackage

// File: rtl/pnod_stream_if.sv
// Interfaces: valid/ready channels for requests, results and register writes.
`timescale 1ns / 1ps
interface pnod_req_if;
   import pnod_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pnod_rsp_if;
   import pnod_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pnod_csr_if;
   import pnod_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pnod_search.sv
// Nearest palette search: distances registered in one stage, combinational 16-way minimum tree in the next.
`timescale 1ns / 1ps
module pnod_search (
   input  logic        clock,
   input  logic        enable,
   input  logic [23:0] color,
   input  logic [pnod_pkg::PALETTE_ENTRIES*24-1:0] table_flat,
   output logic [pnod_pkg::IDX_W-1:0] best_index
);
   import pnod_pkg::*;
   logic [DIST_W-1:0] dist_ff [PALETTE_ENTRIES];
   logic [DIST_W-1:0] dist_in [PALETTE_ENTRIES];
   logic [IDX_W-1:0] best_in;

   always_comb begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         dist_in[i] = color_dist(color, table_flat[i*24 +: 24]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dist_ff <= dist_in;
      end
   end

   // Tree of pairwise minima; the lower index keeps ties.
   always_comb begin
      logic [DIST_W-1:0] d [PALETTE_ENTRIES];
      logic [IDX_W-1:0] k [PALETTE_ENTRIES];
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         d[i] = dist_ff[i];
         k[i] = IDX_W'(i);
      end
      for (int s = 1; s < PALETTE_ENTRIES; s = s * 2) begin
         for (int i = 0; i + s < PALETTE_ENTRIES; i = i + 2 * s) begin
            if (d[i + s] < d[i]) begin
               d[i] = d[i + s];
               k[i] = k[i + s];
            end
         end
      end
      best_in = k[0];
   end

   assign best_index = best_in;
endmodule

// File: rtl/palette_nearest_ordered_dither_top.sv
// Top level: palette quantizer with 4x4 ordered dithering, as a stallable pipeline.
//
//   channel | modport | word
//   req     | sink    | command, pixel, position, palette entry write
//   rsp     | source  | palette index and color, alpha
//   csr     | sink    | register index (0 mode, 1 dither strength) and data
//
// One pixel word enters per cycle unless the output stalls.
// Stages: offset, widen/clamp, first-search distance, first-search minimum,
// second-color lookup, second-search distance, second-search minimum and color read.
// The whole pipeline advances only while its last stage is empty or being taken,
// so a stall holds every word in place. Synchronous reset empties the pipeline,
// loads the default palette and sets mode 2 at strength 1.0.
// A palette write waits at the input until every pixel in flight has left, including
// any held by an output stall, and then updates the table as it is taken,
// so each pixel sees the table as it stood when the pixel entered.
`timescale 1ns / 1ps
module palette_nearest_ordered_dither_top (
   input logic clock,
   input logic reset,
   pnod_req_if.sink   req,
   pnod_rsp_if.source rsp,
   pnod_csr_if.sink   csr
);
   import pnod_pkg::*;
   localparam int N = 7;

   mode_type   mode_ff;
   logic [9:0] strength_ff;
   logic [23:0] pal_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES*24-1:0] table_flat;

   logic       v_ff [N];
   req_type    d_ff [N];
   logic       mode2_ff [N];
   logic       alt_ff [N];
   logic       pass_ff [N];
   logic signed [9:0] off_ff [N];
   logic [23:0] c_ff [N];
   logic [IDX_W-1:0] first_ff, idx_ff;
   logic [IDX_W-1:0] first_d1_ff, first_d2_ff;
   logic [IDX_W-1:0] first_in, second_in;
   logic       advance;
   logic       busy;
   logic       req_take;
   rsp_type    rsp_word;

   // Any pixel still in the pipeline holds back a palette write.
   always_comb begin
      busy = 1'b0;
      for (int i = 0; i < N; i++) busy = busy | v_ff[i];
   end

   assign advance = !v_ff[N-1] || rsp.ready;
   assign req.ready = advance && (req.data.command == CMD_PIXEL || !busy);
   assign req_take = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         table_flat[i*24 +: 24] = pal_ff[i];
      end
   end

   // Stage 0: Bayer offset, full product rounded half away from zero.
   logic signed [6:0]  base_in;
   logic [9:0]         s_in;
   logic signed [17:0] n_in;
   logic [17:0]        mag_in;
   logic signed [9:0]  off_in;
   always_comb begin
      base_in = $signed({3'b000, bayer({req.data.pos_y, req.data.pos_x})}) * 7'sd4 - 7'sd30;
      s_in = strength_ff > 10'd512 ? 10'd512 : strength_ff;
      n_in = 18'(base_in) * $signed({8'd0, s_in});
      mag_in = n_in < 0 ? 18'(-n_in) : 18'(n_in);
      mag_in = (mag_in + 18'd128) >> 8;
      off_in = n_in < 0 ? -$signed(mag_in[9:0]) : $signed(mag_in[9:0]);
   end

   logic [23:0] wide_in;
   always_comb begin
      if (mode2_ff[0] && !alt_ff[0]) begin
         wide_in = {widen(add_clamp(d_ff[0].red, off_ff[0])),
                    widen(add_clamp(d_ff[0].green, off_ff[0])),
                    widen(add_clamp(d_ff[0].blue, off_ff[0]))};
      end else begin
         wide_in = {widen(d_ff[0].red), widen(d_ff[0].green), widen(d_ff[0].blue)};
      end
   end

   logic [23:0] pc;
   logic [23:0] second_color;
   assign pc = pal_ff[first_ff];
   assign second_color = {add_clamp(pc[23:16], off_ff[3]), add_clamp(pc[15:8], off_ff[3]),
                          add_clamp(pc[7:0], off_ff[3])};

   pnod_search u_first (
      .clock(clock), .enable(advance), .color(c_ff[1]),
      .table_flat(table_flat), .best_index(first_in)
   );
   pnod_search u_second (
      .clock(clock), .enable(advance), .color(c_ff[4]),
      .table_flat(table_flat), .best_index(second_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DITHER;
         strength_ff <= 10'd256;
      end else if (csr.valid) begin
         if (csr.data.index == CSR_MODE) mode_ff <= csr.data.data[1:0];
         else strength_ff <= csr.data.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) v_ff[i] <= 1'b0;
         for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            pal_ff[i] <= i < 16 ? default_color(4'(i)) : 24'd0;
         end
      end else if (advance) begin
         v_ff[0] <= req_take && req.data.command == CMD_PIXEL;
         for (int i = 1; i < N; i++) v_ff[i] <= v_ff[i-1];
         if (req_take && req.data.command == CMD_WRITE
             && 32'(req.data.entry_index) < PALETTE_ENTRIES) begin
            pal_ff[IDX_W'(req.data.entry_index)] <= req.data.entry_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff[0] <= req.data;
         mode2_ff[0] <= mode_ff[1];
         pass_ff[0] <= mode_ff == MODE_PASS;
         alt_ff[0] <= s_in == 10'd256;
         off_ff[0] <= (s_in == 10'd256) ? 10'(base_in) : off_in;
         for (int i = 1; i < N; i++) begin
            d_ff[i] <= d_ff[i-1];
            mode2_ff[i] <= mode2_ff[i-1];
            pass_ff[i] <= pass_ff[i-1];
            alt_ff[i] <= alt_ff[i-1];
            off_ff[i] <= off_ff[i-1];
         end
         c_ff[1] <= wide_in;
         first_ff <= first_in;
         c_ff[4] <= second_color;
         idx_ff <= (mode2_ff[5] && alt_ff[5]) ? second_in : first_d2_ff;
         first_d1_ff <= first_ff;
         first_d2_ff <= first_d1_ff;
      end
   end

   logic mode_pass;
   assign mode_pass = pass_ff[N-1];

   logic [23:0] oc;
   assign oc = pal_ff[idx_ff];
   always_comb begin
      rsp_word.out_alpha = d_ff[N-1].alpha;
      if (mode_pass) begin
         rsp_word.palette_index = 4'd0;
         rsp_word.out_red = d_ff[N-1].red;
         rsp_word.out_green = d_ff[N-1].green;
         rsp_word.out_blue = d_ff[N-1].blue;
      end else begin
         rsp_word.palette_index = 4'(idx_ff);
         rsp_word.out_red = oc[23:16];
         rsp_word.out_green = oc[15:8];
         rsp_word.out_blue = oc[7:0];
      end
   end

   assign rsp.valid = v_ff[N-1];
   assign rsp.data = rsp_word;
endmodule

// File: tb/tb_top.sv
// Testbench for the palette quantizer: directed and random words, predicted and checked.
`timescale 1ns / 1ps
module tb_top;
   import pnod_pkg::*;

   logic clock;
   logic reset;

   pnod_req_if req_ch ();
   pnod_rsp_if rsp_ch ();
   pnod_csr_if csr_ch ();

   palette_nearest_ordered_dither_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   // Latency of the pipeline, plus margin.
   localparam int PIPE_DRAIN = 12;
   localparam int WATCHDOG_LIMIT = 20000;

   // Predictor state: our own copy of the palette and of the two registers.
   logic [23:0] pal_model [PALETTE_ENTRIES];
   logic [1:0]  mode_model;
   logic [9:0]  strength_model;

   rsp_type expected_q [$];
   int      fail_count;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Widened channel: keep five bits and replicate the top three.
   function automatic logic [7:0] expand5(input logic [7:0] c);
      return {c[7:3], c[7:5]};
   endfunction

   function automatic logic [7:0] sat_add(input logic [7:0] c, input int off);
      int v;
      v = int'(c) + off;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic int wdist(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [23:0] c);
      int dr, dg, db;
      dr = int'(r) - int'(c[23:16]);
      dg = int'(g) - int'(c[15:8]);
      db = int'(b) - int'(c[7:0]);
      return 3 * dr * dr + 4 * dg * dg + 2 * db * db;
   endfunction

   // Nearest palette entry; strict less-than keeps the lower index on ties.
   function automatic int closest_entry(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
      int best, best_d, d;
      best = 0;
      best_d = wdist(r, g, b, pal_model[0]);
      for (int i = 1; i < PALETTE_ENTRIES; i++) begin
         d = wdist(r, g, b, pal_model[i]);
         if (d < best_d) begin
            best = i;
            best_d = d;
         end
      end
      return best;
   endfunction

   // Works out the quantized word for one pixel, or applies a palette write.
   function automatic bit quantize_pixel(input req_type w, output rsp_type res);
      int idx, m, base, s, n, off;
      logic [23:0] c;
      logic [3:0] bayer_m [16];
      bayer_m = '{4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
                  4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5};
      res = '0;
      if (w.command == CMD_WRITE) begin
         pal_model[w.entry_index] = w.entry_color;
         return 1'b0;
      end
      res.out_alpha = w.alpha;
      if (mode_model == MODE_PASS) begin
         res.palette_index = '0;
         res.out_red = w.red;
         res.out_green = w.green;
         res.out_blue = w.blue;
         return 1'b1;
      end
      if (mode_model == MODE_NEAREST) begin
         idx = closest_entry(expand5(w.red), expand5(w.green), expand5(w.blue));
      end else begin
         m = bayer_m[{w.pos_y, w.pos_x}];
         base = 4 * m - 30;
         s = (strength_model > 10'd512) ? 512 : int'(strength_model);
         if (s == 256) begin
            // Full strength: dither the first match's color and search again.
            c = pal_model[closest_entry(expand5(w.red), expand5(w.green),
                                        expand5(w.blue))];
            idx = closest_entry(sat_add(c[23:16], base), sat_add(c[15:8], base),
                                sat_add(c[7:0], base));
         end else begin
            n = base * s;
            off = (n >= 0) ? (n + 128) / 256 : -((-n + 128) / 256);
            idx = closest_entry(expand5(sat_add(w.red, off)),
                                expand5(sat_add(w.green, off)),
                                expand5(sat_add(w.blue, off)));
         end
      end
      c = pal_model[idx];
      res.palette_index = idx[3:0];
      res.out_red = c[23:16];
      res.out_green = c[15:8];
      res.out_blue = c[7:0];
      return 1'b1;
   endfunction

   // Result side: random stalls, compare every accepted word with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result word with nothing expected: %h", $time, rsp_ch.data);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.data.palette_index !== want.palette_index) begin
                  $display("%0t: palette_index expected %0d actual %0d", $time,
                           want.palette_index, rsp_ch.data.palette_index);
                  fail_count++;
               end
               if (rsp_ch.data.out_red !== want.out_red) begin
                  $display("%0t: out_red expected %0d actual %0d", $time,
                           want.out_red, rsp_ch.data.out_red);
                  fail_count++;
               end
               if (rsp_ch.data.out_green !== want.out_green) begin
                  $display("%0t: out_green expected %0d actual %0d", $time,
                           want.out_green, rsp_ch.data.out_green);
                  fail_count++;
               end
               if (rsp_ch.data.out_blue !== want.out_blue) begin
                  $display("%0t: out_blue expected %0d actual %0d", $time,
                           want.out_blue, rsp_ch.data.out_blue);
                  fail_count++;
               end
               if (rsp_ch.data.out_alpha !== want.out_alpha) begin
                  $display("%0t: out_alpha expected %0d actual %0d", $time,
                           want.out_alpha, rsp_ch.data.out_alpha);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Sends one request word, with a random idle gap first, and records its prediction.
   // Valid stays high after the accepting edge; the next word or wait_idle takes it down.
   task automatic send_word(input req_type w);
      rsp_type res;
      bit idle;
      idle = ($urandom_range(99) < send_idle_pct);
      while (idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         idle = ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (quantize_pixel(w, res)) expected_q.push_back(res);
   endtask

   function automatic req_type pixel_word(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a,
                                          input logic [1:0] x, input logic [1:0] y);
      req_type w;
      w = '0;
      w.command = CMD_PIXEL;
      w.red = r;
      w.green = g;
      w.blue = b;
      w.alpha = a;
      w.pos_x = x;
      w.pos_y = y;
      // Unused fields still get random bits so that the block must ignore them.
      w.entry_index = 4'($urandom);
      w.entry_color = 24'($urandom);
      return w;
   endfunction

   function automatic req_type random_word(input int write_pct);
      req_type w;
      w = pixel_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     2'($urandom), 2'($urandom));
      if ($urandom_range(99) < write_pct) w.command = CMD_WRITE;
      return w;
   endfunction

   // Stops sending, waits until every expected word has arrived, then waits out PIPE_DRAIN.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // Valid stays high after the accepting edge; the caller takes it down.
   task automatic write_reg(input logic index, input logic [9:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= '{index: index, data: value};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (index == CSR_MODE) mode_model = value[1:0];
      else strength_model = value;
   endtask

   task automatic set_mode_strength(input logic [1:0] m, input logic [9:0] s);
      wait_idle();
      write_reg(CSR_MODE, {8'd0, m});
      write_reg(CSR_STRENGTH, s);
      csr_ch.valid <= 1'b0;
   endtask

   // Directed words: field extremes, every mode, full strength and strength saturation.
   task automatic test_directed();
      req_type w;
      // Default settings after reset: mode 2 at full strength.
      send_word(pixel_word(8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 2'd0));
      send_word(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 2'd3));
      send_word(pixel_word(8'h80, 8'h40, 8'hC0, 8'h5A, 2'd0, 2'd3));
      set_mode_strength(MODE_PASS, 10'd0);
      send_word(pixel_word(8'hFF, 8'h00, 8'hAA, 8'h55, 2'd1, 2'd2));
      send_word(pixel_word(8'h00, 8'hFF, 8'h55, 8'hAA, 2'd2, 2'd1));
      set_mode_strength(MODE_NEAREST, 10'd0);
      send_word(pixel_word(8'h1D, 8'h2B, 8'h53, 8'h01, 2'd0, 2'd0));
      send_word(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'h00, 2'd0, 2'd0));
      // Write: entry 15 becomes black, so a black pixel ties entries 0 and 15.
      w = random_word(0);
      w.command = CMD_WRITE;
      w.entry_index = 4'd15;
      w.entry_color = 24'h000000;
      send_word(w);
      send_word(pixel_word(8'h00, 8'h00, 8'h00, 8'h77, 2'd0, 2'd0));
      w.entry_index = 4'd0;
      w.entry_color = 24'hFFFFFF;
      send_word(w);
      send_word(pixel_word(8'h00, 8'h00, 8'h00, 8'h78, 2'd0, 2'd0));
      send_word(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'h79, 2'd0, 2'd0));
      // Strength at zero, at maximum, and above the clamp.
      set_mode_strength(MODE_DITHER, 10'd0);
      send_word(pixel_word(8'h7F, 8'h7F, 8'h7F, 8'h10, 2'd3, 2'd0));
      set_mode_strength(MODE_DITHER, 10'd512);
      send_word(pixel_word(8'h7F, 8'h7F, 8'h7F, 8'h11, 2'd0, 2'd3));
      send_word(pixel_word(8'h02, 8'hFD, 8'h80, 8'h12, 2'd0, 2'd0));
      set_mode_strength(MODE_DITHER, 10'h3FF);
      send_word(pixel_word(8'h7F, 8'h7F, 8'h7F, 8'h13, 2'd0, 2'd3));
      // Mode three acts as mode two.
      set_mode_strength(2'd3, 10'd256);
      send_word(pixel_word(8'h40, 8'hA0, 8'h20, 8'h14, 2'd2, 2'd2));
      send_word(pixel_word(8'hFF, 8'h00, 8'h4D, 8'h15, 2'd1, 2'd1));
   endtask

   // Random words in a range of settings; mostly pixels, some palette writes.
   task automatic test_random(input int count);
      for (int k = 0; k < count; k++) begin
         if (k % 100 == 0) begin
            case ($urandom_range(5))
               0: set_mode_strength(MODE_PASS, 10'($urandom));
               1: set_mode_strength(MODE_NEAREST, 10'($urandom));
               2: set_mode_strength(MODE_DITHER, 10'd256);
               3: set_mode_strength(MODE_DITHER, 10'($urandom_range(512)));
               4: set_mode_strength(2'($urandom), 10'($urandom));
               default: set_mode_strength(MODE_DITHER, 10'($urandom_range(1023, 513)));
            endcase
         end
         send_word(random_word(8));
      end
   endtask

   // The sender holds off until every expected word has come back.
   task automatic test_drain_pause();
      for (int k = 0; k < 20; k++) send_word(random_word(10));
      wait_idle();
      for (int k = 0; k < 20; k++) send_word(random_word(10));
   endtask

   initial begin
      fail_count = 0;
      send_idle_pct = 14;
      recv_idle_pct = 85;
      for (int i = 0; i < PALETTE_ENTRIES; i++) pal_model[i] = '0;
      pal_model = '{24'h000000, 24'h1D2B53, 24'h7E2553, 24'h008751,
                    24'hAB5236, 24'h5F574F, 24'hC2C3C7, 24'hFFF1E8,
                    24'hFF004D, 24'hFFA300, 24'hFFEC27, 24'h00E436,
                    24'h29ADFF, 24'h83769C, 24'hFF77A8, 24'hFFCCAA};
      mode_model = MODE_DITHER;
      strength_model = 10'd256;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(300);
      test_drain_pause();
      send_idle_pct = 85;
      recv_idle_pct = 14;
      test_random(700);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(800);

      wait_idle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
